>>> rtl/ngbft_pkg.sv
// shared constants and types for the n-gram block frequency table
package ngbft_pkg;

  localparam int DEF_MAX_BLOCK   = 8;
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_SYMBOL_BITS = 8;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] BLEN_RESET = CFG_BITS'(1);

  typedef struct packed {
    logic valid;
    logic formed;
    logic fin;
    logic found;
    logic is_new;
  } req_ctl_t;

endpackage

>>> rtl/ngbft_if.sv
// channel interfaces for symbols, results and configuration
interface ngbft_sym_if #(
  parameter int SYMBOL_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [SYMBOL_BITS-1:0] symbol;
  logic                   final_req;

  modport source (output valid, output symbol, output final_req, input ready);
  modport sink (input valid, input symbol, input final_req, output ready);
endinterface

interface ngbft_res_if #(
  parameter int IDX_BITS   = 6,
  parameter int COUNT_BITS = 16,
  parameter int USED_BITS  = 7
);
  logic                  valid;
  logic                  ready;
  logic                  block_formed;
  logic [IDX_BITS-1:0]   entry_index;
  logic                  is_new;
  logic [COUNT_BITS-1:0] entry_count;
  logic [USED_BITS-1:0]  distinct_blocks;
  logic                  table_full;
  logic                  is_last;

  modport source (output valid, output block_formed, output entry_index, output is_new,
                  output entry_count, output distinct_blocks, output table_full,
                  output is_last, input ready);
  modport sink (input valid, input block_formed, input entry_index, input is_new,
                input entry_count, input distinct_blocks, input table_full,
                input is_last, output ready);
endinterface

interface ngbft_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ngbft_pkg::CFG_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ngbft_front.sv
// symbol window, block length register and block assembly stage
module ngbft_front #(
  parameter int MAX_BLOCK   = 8,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  sym_accept,
  input  logic [SYMBOL_BITS-1:0]                symbol,
  input  logic                                  final_req,
  input  logic                                  cfg_write,
  input  logic [ngbft_pkg::CFG_BITS-1:0]        cfg_data,
  output ngbft_pkg::req_ctl_t                   out_ctl,
  output logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] out_blk
);
  import ngbft_pkg::*;

  localparam int FILL_BITS = $clog2(MAX_BLOCK + 1);
  localparam int CW        = (FILL_BITS > CFG_BITS + 1) ? FILL_BITS : CFG_BITS + 1;
  localparam int WIN_IW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  logic [CFG_BITS-1:0]                   blen;
  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] win;
  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] win_next;
  logic [FILL_BITS-1:0]                  fill;
  logic [FILL_BITS-1:0]                  fill_next;
  logic [CW-1:0]                         len;
  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] blk;
  logic [CW-1:0]                         sel;

  always_comb begin
    win_next[0] = symbol;
    for (int i = 1; i < MAX_BLOCK; i++) begin
      win_next[i] = win[i-1];
    end
    fill_next = (fill == FILL_BITS'(MAX_BLOCK)) ? fill : fill + FILL_BITS'(1);
    if (blen == '0) begin
      len = CW'(1);
    end else if (CW'(blen) > CW'(MAX_BLOCK)) begin
      len = CW'(MAX_BLOCK);
    end else begin
      len = CW'(blen);
    end
  end

  always_comb begin
    blk = '0;
    sel = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      sel = len - CW'(1) - CW'(j);
      if (CW'(j) < len) begin
        blk[j] = win_next[sel[WIN_IW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blen    <= BLEN_RESET;
      win     <= '0;
      fill    <= '0;
      out_ctl <= '0;
    end else begin
      if (cfg_write) begin
        blen <= cfg_data;
      end
      if (sym_accept) begin
        if (final_req) begin
          win  <= '0;
          fill <= '0;
        end else begin
          win  <= win_next;
          fill <= fill_next;
        end
      end
      if (adv) begin
        out_ctl.valid  <= sym_accept;
        out_ctl.formed <= CW'(fill_next) >= len;
        out_ctl.fin    <= final_req;
        out_ctl.found  <= 1'b0;
        out_ctl.is_new <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blk <= blk;
    end
  end

endmodule

>>> rtl/ngbft_cell.sv
// one table entry with its compare, update and request stage
module ngbft_cell #(
  parameter int MAX_BLOCK   = 8,
  parameter int SYMBOL_BITS = 8,
  parameter int COUNT_BITS  = 16,
  parameter int IDX_BITS    = 6,
  parameter int USED_BITS   = 7,
  parameter int CELL_INDEX  = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  ngbft_pkg::req_ctl_t                   in_ctl,
  input  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] in_blk,
  input  logic [IDX_BITS-1:0]                   in_idx,
  input  logic [COUNT_BITS-1:0]                 in_cnt,
  input  logic [USED_BITS-1:0]                  in_used,
  output ngbft_pkg::req_ctl_t                   out_ctl,
  output logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] out_blk,
  output logic [IDX_BITS-1:0]                   out_idx,
  output logic [COUNT_BITS-1:0]                 out_cnt,
  output logic [USED_BITS-1:0]                  out_used
);
  import ngbft_pkg::*;

  logic                                  held;
  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] store;
  logic [COUNT_BITS-1:0]                 count;
  logic [COUNT_BITS-1:0]                 count_inc;
  logic                                  lookup;
  logic                                  hit;
  logic                                  claim;
  req_ctl_t                              ctl_next;

  always_comb begin
    lookup    = in_ctl.valid && in_ctl.formed && !in_ctl.found;
    hit       = lookup && held && (store == in_blk);
    claim     = lookup && !held;
    count_inc = (count == '1) ? count : count + COUNT_BITS'(1);
    ctl_next        = in_ctl;
    ctl_next.found  = in_ctl.found || hit || claim;
    ctl_next.is_new = in_ctl.is_new || claim;
  end

  // entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (adv && in_ctl.valid) begin
      if (in_ctl.fin) begin
        held <= 1'b0;
      end else if (claim) begin
        held <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (claim) begin
        store <= in_blk;
        count <= COUNT_BITS'(1);
      end else if (hit) begin
        count <= count_inc;
      end
    end
  end

  // request moves on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (adv) begin
      out_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blk <= in_blk;
      if (hit || claim) begin
        out_idx <= IDX_BITS'(CELL_INDEX);
      end else begin
        out_idx <= in_idx;
      end
      if (hit) begin
        out_cnt <= count_inc;
      end else if (claim) begin
        out_cnt <= COUNT_BITS'(1);
      end else begin
        out_cnt <= in_cnt;
      end
      if (held || claim) begin
        out_used <= in_used + USED_BITS'(1);
      end else begin
        out_used <= in_used;
      end
    end
  end

endmodule

>>> rtl/ngram_block_frequency_table.sv
// top level: window stage followed by a chain of table entry cells
//
//  channel   dir  handshake      payload
//  symbols   in   valid/ready    symbol, final_req
//  results   out  valid/ready    block_formed, entry_index, is_new, entry_count,
//                                distinct_blocks, table_full, is_last
//  cfg       in   valid/ready    data (symbols per block), always ready
//
// one symbol a cycle while no result is stalled; each request walks the cell chain one
// entry a cycle, likewise unless stalled, from the window stage register through the cells
// a stalled result holds the whole chain; symbols are refused while it waits
// reset clears the window and every entry's in-use flag and sets the block length to one
// the request after a final one sees each cell already cleared
module ngram_block_frequency_table #(
  parameter int MAX_BLOCK   = ngbft_pkg::DEF_MAX_BLOCK,
  parameter int TABLE_DEPTH = ngbft_pkg::DEF_TABLE_DEPTH,
  parameter int SYMBOL_BITS = ngbft_pkg::DEF_SYMBOL_BITS,
  parameter int COUNT_BITS  = ngbft_pkg::DEF_COUNT_BITS
) (
  input logic         clk,
  input logic         rst,
  ngbft_sym_if.sink   symbols,
  ngbft_res_if.source results,
  ngbft_cfg_if.sink   cfg
);
  import ngbft_pkg::*;

  localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_BITS = $clog2(TABLE_DEPTH + 1);

  req_ctl_t                              ctl  [TABLE_DEPTH+1];
  logic [MAX_BLOCK-1:0][SYMBOL_BITS-1:0] blk  [TABLE_DEPTH+1];
  logic [IDX_BITS-1:0]                   idx  [TABLE_DEPTH+1];
  logic [COUNT_BITS-1:0]                 cnt  [TABLE_DEPTH+1];
  logic [USED_BITS-1:0]                  used [TABLE_DEPTH+1];
  logic                                  adv;
  logic                                  sym_accept;
  req_ctl_t                              last;

  assign last       = ctl[TABLE_DEPTH];
  assign adv        = !last.valid || results.ready;
  assign sym_accept = symbols.valid && adv;

  assign symbols.ready = adv;
  assign cfg.ready     = 1'b1;

  ngbft_front #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .sym_accept (sym_accept),
    .symbol     (symbols.symbol),
    .final_req  (symbols.final_req),
    .cfg_write  (cfg.valid),
    .cfg_data   (cfg.data),
    .out_ctl    (ctl[0]),
    .out_blk    (blk[0])
  );

  assign idx[0]  = '0;
  assign cnt[0]  = '0;
  assign used[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ngbft_cell #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SYMBOL_BITS (SYMBOL_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .IDX_BITS    (IDX_BITS),
      .USED_BITS   (USED_BITS),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (ctl[g]),
      .in_blk   (blk[g]),
      .in_idx   (idx[g]),
      .in_cnt   (cnt[g]),
      .in_used  (used[g]),
      .out_ctl  (ctl[g+1]),
      .out_blk  (blk[g+1]),
      .out_idx  (idx[g+1]),
      .out_cnt  (cnt[g+1]),
      .out_used (used[g+1])
    );
  end

  assign results.valid           = last.valid;
  assign results.block_formed    = last.formed;
  assign results.entry_index     = idx[TABLE_DEPTH];
  assign results.is_new          = last.is_new;
  assign results.entry_count     = cnt[TABLE_DEPTH];
  assign results.distinct_blocks = used[TABLE_DEPTH];
  assign results.table_full      = last.formed && !last.found;
  assign results.is_last         = last.fin;

endmodule
